// File: rtl/n2a_pkg.sv
package n2a_pkg;

  // Format selector codes
  localparam logic [2:0] OP_HEX_0X = 3'd0;
  localparam logic [2:0] OP_HEX_X  = 3'd1;
  localparam logic [2:0] OP_DEC3   = 3'd2;
  localparam logic [2:0] OP_DEC_SH = 3'd3;
  localparam logic [2:0] OP_DEC5   = 3'd4;

  // ASCII constants
  localparam logic [6:0] CHR_ZERO  = 7'h30;
  localparam logic [6:0] CHR_X     = 7'h78;
  localparam logic [6:0] CHR_UPA   = 7'h41;

  localparam int unsigned MAX_CHARS = 5;

  // Item handed from the digit pipeline to the serializer
  typedef struct packed {
    logic [2:0]                 op;
    logic [7:0]                 val_lo;  // low byte, used by the hex formats
    logic [MAX_CHARS-1:0][3:0]  dig;     // decimal digits, dig[0] is the ones digit
  } n2a_item_t;

endpackage

// File: rtl/n2a_conv.sv
module n2a_conv import n2a_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_op,
  input  logic [15:0] in_value,
  output logic       out_valid,
  input  logic       out_ready,
  output n2a_item_t  out_item
);

  // Quotient by ten for values below 100: (y * 205) >> 11 is exact there.
  function automatic logic [3:0] div10(input logic [6:0] y);
    logic [14:0] p;
    p = y * 8'd205;
    return p[14:11];
  endfunction

  function automatic logic [6:0] times10(input logic [3:0] t);
    return {t, 3'b000} + {2'b00, t, 1'b0};
  endfunction

  // Stage 1: captured input
  logic        v1_r;
  logic [2:0]  op1_r;
  logic [15:0] val1_r;
  // Stage 2: number split by 100
  logic        v2_r;
  logic [2:0]  op2_r;
  logic [7:0]  lo8_2_r;
  logic [9:0]  q2_r;
  logic [6:0]  rem2_r;
  // Stage 3: top digit, middle pair, low digits
  logic        v3_r;
  logic [2:0]  op3_r;
  logic [7:0]  lo8_3_r;
  logic [3:0]  top3_r;
  logic [6:0]  mid3_r;
  logic [3:0]  lot3_r;
  logic [3:0]  loo3_r;
  // Stage 4: all digits
  logic        v4_r;
  n2a_item_t   item4_r;

  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Stage 2 datapath: q = num / 100 via reciprocal 83887 / 2^23 (exact below 91180)
  logic [15:0] num1;
  logic [32:0] prod1;
  logic [9:0]  q1;
  logic [15:0] q100;
  logic [15:0] rem1;

  assign num1  = (op1_r == OP_DEC5) ? val1_r : {8'h00, val1_r[7:0]};
  assign prod1 = num1 * 17'd83887;
  assign q1    = prod1[32:23];
  assign q100  = {q1, 6'b0} + {1'b0, q1, 5'b0} + {4'b0, q1, 2'b0};
  assign rem1  = num1 - q100;

  // Stage 3 datapath: top = q / 100 via 41 / 2^12 (exact below 1024)
  logic [15:0] prod2;
  logic [3:0]  top2;
  logic [9:0]  top100;
  logic [9:0]  mid2;
  logic [3:0]  lot2;
  logic [6:0]  loo2;

  assign prod2  = q2_r * 6'd41;
  assign top2   = prod2[15:12];
  assign top100 = {top2, 6'b0} + {1'b0, top2, 5'b0} + {4'b0, top2, 2'b0};
  assign mid2   = q2_r - top100;
  assign lot2   = div10(rem2_r);
  assign loo2   = rem2_r - times10(lot2);

  // Stage 4 datapath: split middle pair
  logic [3:0] midt3;
  logic [6:0] mido3;

  assign midt3 = div10(mid3_r);
  assign mido3 = mid3_r - times10(midt3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      op1_r  <= in_op;
      val1_r <= in_value;
    end
    if (rdy2 && v1_r) begin
      op2_r   <= op1_r;
      lo8_2_r <= val1_r[7:0];
      q2_r    <= q1;
      rem2_r  <= rem1[6:0];
    end
    if (rdy3 && v2_r) begin
      op3_r   <= op2_r;
      lo8_3_r <= lo8_2_r;
      top3_r  <= top2;
      mid3_r  <= mid2[6:0];
      lot3_r  <= lot2;
      loo3_r  <= loo2[3:0];
    end
    if (rdy4 && v3_r) begin
      item4_r.op     <= op3_r;
      item4_r.val_lo <= lo8_3_r;
      item4_r.dig[4] <= top3_r;
      item4_r.dig[3] <= midt3;
      item4_r.dig[2] <= mido3[3:0];
      item4_r.dig[1] <= lot3_r;
      item4_r.dig[0] <= loo3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_item  = item4_r;

endmodule

// File: rtl/n2a_ser.sv
module n2a_ser import n2a_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  n2a_item_t  in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_last
);

  function automatic logic [6:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) return CHR_ZERO + {3'b000, d};
    else           return CHR_UPA + {3'b000, d} - 7'd10;
  endfunction

  function automatic logic [6:0] dec_char(input logic [3:0] d);
    return CHR_ZERO + {3'b000, d};
  endfunction

  logic [MAX_CHARS-1:0][6:0] ch;
  logic [2:0]                cnt;

  // Build the text, first character in slot 0
  always_comb begin
    ch  = '0;
    cnt = 3'd0;
    unique case (in_item.op)
      OP_HEX_0X: begin
        ch[0] = CHR_ZERO;
        ch[1] = CHR_X;
        ch[2] = hex_char(in_item.val_lo[7:4]);
        ch[3] = hex_char(in_item.val_lo[3:0]);
        cnt   = 3'd4;
      end
      OP_HEX_X: begin
        ch[0] = CHR_X;
        ch[1] = hex_char(in_item.val_lo[7:4]);
        ch[2] = hex_char(in_item.val_lo[3:0]);
        cnt   = 3'd3;
      end
      OP_DEC3: begin
        ch[0] = dec_char(in_item.dig[2]);
        ch[1] = dec_char(in_item.dig[1]);
        ch[2] = dec_char(in_item.dig[0]);
        cnt   = 3'd3;
      end
      OP_DEC_SH: begin
        if (in_item.dig[2] != 4'd0) begin
          ch[0] = dec_char(in_item.dig[2]);
          ch[1] = dec_char(in_item.dig[1]);
          ch[2] = dec_char(in_item.dig[0]);
          cnt   = 3'd3;
        end else if (in_item.dig[1] != 4'd0) begin
          ch[0] = dec_char(in_item.dig[1]);
          ch[1] = dec_char(in_item.dig[0]);
          cnt   = 3'd2;
        end else begin
          ch[0] = dec_char(in_item.dig[0]);
          cnt   = 3'd1;
        end
      end
      OP_DEC5: begin
        for (int i = 0; i < MAX_CHARS; i++) begin
          ch[i] = dec_char(in_item.dig[MAX_CHARS-1-i]);
        end
        cnt = 3'd5;
      end
      default: begin
        cnt = 3'd0;  // unknown selector: no text
      end
    endcase
  end

  logic [MAX_CHARS-1:0][6:0] buf_r;
  logic [2:0]                rem_r;
  logic                      vld_r;
  logic                      load_ok;

  assign load_ok  = !vld_r || (out_ready && rem_r == 3'd1);
  assign in_ready = load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      rem_r <= 3'd0;
    end else if (load_ok) begin
      vld_r <= in_valid && (cnt != 3'd0);
      rem_r <= in_valid ? cnt : 3'd0;
    end else if (out_ready) begin
      rem_r <= rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      buf_r <= ch;
    end else if (out_ready) begin
      for (int i = 0; i < MAX_CHARS - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
      buf_r[MAX_CHARS-1] <= '0;
    end
  end

  assign out_valid = vld_r;
  assign out_char  = buf_r[0];
  assign out_last  = (rem_r == 3'd1);

endmodule

// File: rtl/number_to_ascii_formatter.sv
// Channel  | Ports                          | Contents
// ---------+--------------------------------+-------------------------------------------
// in       | in_tvalid/in_tready/in_tdata/  | number to print in tdata,
//          | in_tuser                       | format selector in tuser
// out      | out_tvalid/out_tready/         | one ASCII character per transaction,
//          | out_tdata/out_tlast            | most significant first, tlast on the final
//
// Each number yields one to five characters, one per cycle while out_tready is
// high; the output serializer sets that rate and loads the next number as the
// last character of the previous one goes out. Input to first character passes
// through the four-stage digit pipeline and the serializer register.
// rst_n is synchronous, active low, and empties every stage. A stall on the
// output holds the serializer, and the pipeline keeps taking transactions until
// all four stages are full. Unknown selectors are dropped without output.
module number_to_ascii_formatter import n2a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] value
  input  logic [2:0]  in_tuser,   // [2:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] character, [7] zero
  output logic        out_tlast
);

  n2a_item_t  item;
  logic       item_valid;
  logic       item_ready;
  logic [6:0] chr;

  // Digit extraction: split the number into decimal digits over four stages
  n2a_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_value  (in_tdata),
    .out_valid (item_valid),
    .out_ready (item_ready),
    .out_item  (item)
  );

  // Format and shift out the characters, one transaction per cycle while out_tready is high
  n2a_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .in_item   (item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (chr),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, chr};

endmodule

// File: bench/testbench.sv
module testbench import n2a_pkg::*;;

  localparam int unsigned NUM_ITEMS   = 415;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 24;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  // Holds the characters still owed by the block, oldest first.
  class ascii_text_board;
    text_char_t pending_text[$];
    int         failures;

    function new();
      failures = 0;
    endfunction

    static function logic [6:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) return CHR_ZERO + 7'(nib);
      return CHR_UPA + 7'(nib) - 7'd10;
    endfunction

    static function logic [6:0] dec_char(int unsigned d);
      return CHR_ZERO + 7'(d);
    endfunction

    // Compute the text of one accepted number and queue it.
    function void note_number(logic [2:0] op, logic [15:0] value);
      logic [6:0]  text[$];
      logic [7:0]  v8;
      int unsigned hund, tens, ones, div;
      text_char_t  c;
      v8   = value[7:0];
      hund = v8 / 100;
      tens = (v8 / 10) % 10;
      ones = v8 % 10;
      case (op)
        OP_HEX_0X: begin
          text.push_back(CHR_ZERO);
          text.push_back(CHR_X);
          text.push_back(hex_char(v8[7:4]));
          text.push_back(hex_char(v8[3:0]));
        end
        OP_HEX_X: begin
          text.push_back(CHR_X);
          text.push_back(hex_char(v8[7:4]));
          text.push_back(hex_char(v8[3:0]));
        end
        OP_DEC3: begin
          text.push_back(dec_char(hund));
          text.push_back(dec_char(tens));
          text.push_back(dec_char(ones));
        end
        OP_DEC_SH: begin
          // drop leading zeros, keep the ones digit
          if (hund != 0) text.push_back(dec_char(hund));
          if (hund != 0 || tens != 0) text.push_back(dec_char(tens));
          text.push_back(dec_char(ones));
        end
        OP_DEC5: begin
          div = 10000;
          for (int i = 0; i < 5; i++) begin
            text.push_back(dec_char((int'(value) / div) % 10));
            div = div / 10;
          end
        end
        default: ;  // unknown selector: no text at all
      endcase
      foreach (text[i]) begin
        c.ch   = text[i];
        c.last = (i == text.size() - 1);
        pending_text.push_back(c);
      end
    endfunction

    function void check_char(logic [6:0] ch, logic last);
      text_char_t want;
      if (pending_text.size() == 0) begin
        $error("unexpected character: character=%h last=%b", ch, last);
        failures++;
        return;
      end
      want = pending_text.pop_front();
      if (ch !== want.ch) begin
        $error("character mismatch: expected %h, actual %h", want.ch, ch);
        failures++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %b, actual %b", want.last, last);
        failures++;
      end
    endfunction

    function int owed();
      return pending_text.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;     // [15:0] value
  logic [2:0]  in_tuser = '0;     // [2:0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [6:0] character, [7] zero
  logic        out_tlast;

  ascii_text_board board = new();
  int unsigned     cycle_count = 0;
  int unsigned     sent_count = 0;
  int unsigned     rx_stall = 0;

  number_to_ascii_formatter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  // Watchdog: a correct run is far below this, so hitting it means a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Mostly no pause, sometimes a few cycles, now and then a long one.
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver backpressure. While cycle_count[9:8] is 3 it runs at full rate so
  // the block also sees long stretches with no stall at all.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (((cycle_count >> 8) & 3) == 3) begin
      out_tready <= 1'b1;
      rx_stall   <= 0;
    end else if (rx_stall != 0) begin
      out_tready <= 1'b0;
      rx_stall   <= rx_stall - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      // start a stall this cycle; the rest of it counts down above
      out_tready <= 1'b0;
      rx_stall   <= pause_len();
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check every character transaction against the oldest owed character.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_char(out_tdata[6:0], out_tlast);
    end
  end

  // Present one number, hold it until the handshake, then maybe pause.
  // Entered and left at a falling edge; valid stays high between
  // back-to-back transactions, only the data changes.
  task automatic send_number(input logic [2:0] op, input logic [15:0] value,
                             input bit no_gap);
    int unsigned gap;
    in_tdata  = value;
    in_tuser  = op;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    board.note_number(op, value);
    sent_count++;
    @(negedge clk);
    gap = no_gap ? 0 : pause_len();
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Random number biased toward the digit and prefix corner cases.
  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    int unsigned r;
    v = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 20) begin
      v[7:0] = 8'($urandom_range(0, 9));
    end else if (r < 35) begin
      v[7:0] = 8'($urandom_range(0, 99));
    end else if (r < 50) begin
      case ($urandom_range(0, 5))
        0: v[7:0] = 8'd0;
        1: v[7:0] = 8'd9;
        2: v[7:0] = 8'd10;
        3: v[7:0] = 8'd99;
        4: v[7:0] = 8'd100;
        default: v[7:0] = 8'd255;
      endcase
    end else if (r < 55) begin
      v = 16'($urandom_range(0, 99));
    end
    return v;
  endfunction

  initial begin
    logic [2:0]  op;
    int unsigned counted;
    bit          burst;

    // hold reset, release at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: every format at the field extremes, the leading-zero edges of
    // the short decimal format, ignored high byte, and the unknown selectors.
    send_number(OP_HEX_0X, 16'h0000, 1'b0);
    send_number(OP_HEX_0X, 16'hFFFF, 1'b1);
    send_number(OP_HEX_0X, 16'h12A5, 1'b0);
    send_number(OP_HEX_X,  16'h00FF, 1'b1);
    send_number(OP_HEX_X,  16'hAB09, 1'b0);
    send_number(OP_DEC3,   16'h0000, 1'b1);
    send_number(OP_DEC3,   16'h00FF, 1'b0);
    send_number(OP_DEC3,   16'hFF64, 1'b1);
    send_number(OP_DEC_SH, 16'd0,    1'b1);
    send_number(OP_DEC_SH, 16'd9,    1'b1);
    send_number(OP_DEC_SH, 16'd10,   1'b0);
    send_number(OP_DEC_SH, 16'd99,   1'b1);
    send_number(OP_DEC_SH, 16'd100,  1'b1);
    send_number(OP_DEC_SH, 16'd255,  1'b0);
    send_number(OP_DEC_SH, 16'hFF05, 1'b1);
    send_number(OP_DEC5,   16'd0,    1'b1);
    send_number(OP_DEC5,   16'd65535, 1'b0);
    send_number(OP_DEC5,   16'd10000, 1'b1);
    send_number(OP_DEC5,   16'd9999, 1'b1);
    send_number(OP_DEC5,   16'd1,    1'b0);
    send_number(3'd5,      16'h1234, 1'b1);
    send_number(3'd6,      16'hFFFF, 1'b1);
    send_number(OP_DEC_SH, 16'd7,    1'b1);
    send_number(3'd7,      16'h0000, 1'b0);
    send_number(OP_HEX_X,  16'h5A00, 1'b1);

    // Random: unknown selectors now and then, uncounted since they yield
    // nothing. Every 64 numbers, 16 go back to back.
    counted = 0;
    while (counted < NUM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) op = 3'($urandom_range(5, 7));
      else op = 3'($urandom_range(0, 4));
      burst = ((counted % 64) >= 48);
      send_number(op, pick_value(), burst);
      if (op <= OP_DEC5) counted++;
    end
    in_tvalid = 1'b0;

    // drain: wait for every owed character, then watch for strays
    while (board.owed() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (board.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
